// ----- rtl/deq_pkg.sv -----
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH_REAR  = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_POP_REAR   = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_CLEAR      = 3'd4,
        FUNC_QUERY      = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_EMPTY      = 2'd2
    } t_status;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic f_shr;   // front chain moves one cell toward the back
        logic f_shl;   // front chain moves one cell toward the front
        logic f_wr;    // front chain writes the cell at the count
        logic r_shr;   // rear chain moves one cell away from the rear
        logic r_shl;   // rear chain moves one cell toward the rear
        logic r_wr;    // rear chain writes the cell at the count
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/deq_cell.sv -----
// one queue cell: an entry of the front-ordered chain and of the rear-ordered chain
`default_nettype none

module deq_cell
    import deq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [CW-1:0]        i_count,
    input  wire logic signed [31:0]   i_value,
    input  wire logic signed [31:0]   i_f_left,
    input  wire logic signed [31:0]   i_f_right,
    input  wire logic signed [31:0]   i_r_left,
    input  wire logic signed [31:0]   i_r_right,
    output logic signed [31:0]        o_f,
    output logic signed [31:0]        o_r
);

    logic               hit;
    logic signed [31:0] r_f;
    logic signed [31:0] r_r;

    assign hit = (i_count == CW'(IDX));

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.f_shr) begin
            r_f <= i_f_left;
        end else if (i_ctl.f_shl) begin
            r_f <= i_f_right;
        end else if (i_ctl.f_wr && hit) begin
            r_f <= i_value;
        end else begin
            r_f <= r_f;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.r_shr) begin
            r_r <= i_r_left;
        end else if (i_ctl.r_shl) begin
            r_r <= i_r_right;
        end else if (i_ctl.r_wr && hit) begin
            r_r <= i_value;
        end else begin
            r_r <= r_r;
        end
    end

    assign o_f = r_f;
    assign o_r = r_r;

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue_unit.sv -----
// top level of the double-ended queue: control, count and the row of cells
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_func, i_value
//  result   out        o_valid / i_stall  o_status, o_front_value, o_rear_value,
//                                         o_count, o_is_empty
//
// one transaction per cycle while o_stall is low; each one updates the cell row and the count
// and its result is shown on the next cycle from the cells at the two chain heads.
// the front chain keeps the front entry in cell 0, the rear chain the rear entry.
// reset clears the count and the output valid; cell contents are left as they are.
// a new transaction is taken while the result waits only if that result leaves now.
`default_nettype none

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [2:0]                      i_func,
    input  wire logic signed [31:0]              i_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [1:0]                           o_status,
    output logic signed [31:0]                   o_front_value,
    output logic signed [31:0]                   o_rear_value,
    output logic [$clog2(DEPTH+1)-1:0]           o_count,
    output logic                                 o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    logic               accept;
    logic               full;
    logic               empty;
    t_func              func;
    t_cell_ctl          ctl;
    t_status            status;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    t_status            r_status;
    logic               r_out_valid;
    logic signed [31:0] f_q [DEPTH];
    logic signed [31:0] r_q [DEPTH];

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign func    = t_func'(i_func);

    always_comb begin
        ctl     = '0;
        status  = STATUS_DONE;
        n_count = r_count;
        unique case (func)
            FUNC_PUSH_REAR: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    ctl.f_wr  = 1'b1;
                    ctl.r_shr = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            FUNC_PUSH_FRONT: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    ctl.f_shr = 1'b1;
                    ctl.r_wr  = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            FUNC_POP_REAR: begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    ctl.r_shl = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            FUNC_POP_FRONT: begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    ctl.f_shl = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // query and the unused codes change nothing
            end
        endcase
        if (!accept) begin
            ctl     = '0;
            n_count = r_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [31:0] f_left;
            logic signed [31:0] f_right;
            logic signed [31:0] r_left;
            logic signed [31:0] r_right;

            if (g == 0) begin : g_head
                assign f_left = i_value;
                assign r_left = i_value;
            end else begin : g_mid_l
                assign f_left = f_q[g-1];
                assign r_left = r_q[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign f_right = f_q[g];
                assign r_right = r_q[g];
            end else begin : g_mid_r
                assign f_right = f_q[g+1];
                assign r_right = r_q[g+1];
            end

            deq_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl),
                .i_count   (r_count),
                .i_value   (i_value),
                .i_f_left  (f_left),
                .i_f_right (f_right),
                .i_r_left  (r_left),
                .i_r_right (r_right),
                .o_f       (f_q[g]),
                .o_r       (r_q[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
        end
    end

    // state only moves on a transaction, so the heads stay put while a result waits
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_front_value = empty ? INT_MIN : f_q[0];
    assign o_rear_value  = empty ? INT_MIN : r_q[0];
    assign o_count       = r_count;
    assign o_is_empty    = empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above depth");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (func == FUNC_PUSH_REAR || func == FUNC_PUSH_FRONT)
        |=> r_count == $past(r_count) && r_status == STATUS_FULL)
        else $error("rejected push changed the count");

    a_pop_front_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !empty && func == FUNC_POP_FRONT
        |=> r_count == $past(r_count) - 1'b1)
        else $error("pop front did not decrement the count");

    a_push_front_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !full && func == FUNC_PUSH_FRONT
        |=> f_q[0] == $past(i_value) && o_front_value == $past(i_value))
        else $error("pushed value not at the front");

    a_push_rear_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !full && func == FUNC_PUSH_REAR
        |=> o_rear_value == $past(i_value))
        else $error("pushed value not at the rear");
`endif

endmodule

`default_nettype wire
